// File: rtl/byb_pkg.sv
`default_nettype none

package byb_pkg;

    // longest bond in periods
    localparam int MAX_PERIODS = 1024;

    // payload widths
    localparam int MONEY_W = 64;
    localparam int RATE_W  = 32;
    localparam int M_W     = 4;
    localparam int N_W     = 11;
    localparam int STAT_W  = 2;
    localparam int TOL_W   = 32;
    localparam int ITER_W  = 16;
    localparam int CFG_W   = 32;

    // discount factor and powers, Q1.28 up to 1.0
    localparam int DF_W = 29;
    localparam logic [DF_W-1:0] ONE_Q28 = DF_W'(1) << 28;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_CONVERGED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_BRACKET = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;

    // configuration register indexes
    localparam logic CFG_TOL  = 1'b0;
    localparam logic CFG_ITER = 1'b1;

    // product scaled down by 2^28, saturated to 64 bits
    function automatic logic [63:0] sat_q28(input logic [127:0] p);
        logic [63:0] r;
        if (p[127:92] != 36'd0) begin
            r = {64{1'b1}};
        end else begin
            r = p[91:28];
        end
        return r;
    endfunction

    // saturating 64-bit add
    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/byb_div.sv
`default_nettype none

// restoring divider, one quotient bit a cycle, 64-bit quotient
module byb_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [32:0] den,
    output logic      [63:0] quot,
    output logic             done
);

    logic [33:0] rem_reg, rem_next;
    logic [63:0] quot_reg, quot_next;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] trial;

    // one shift-subtract step
    always_comb begin
        trial = {rem_reg[32:0], quot_reg[63]};
        if (trial >= {1'b0, den_reg}) begin
            rem_next  = trial - {1'b0, den_reg};
            quot_next = {quot_reg[62:0], 1'b1};
        end else begin
            rem_next  = trial;
            quot_next = {quot_reg[62:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= num;
            den_reg  <= den;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/byb_mul.sv
`default_nettype none

// 64x64 multiplier from four 32x32 partial products, registered between
module byb_mul (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic      [127:0] prod,
    output logic              done
);

    logic [63:0]  a_reg, b_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   sh_reg;
    logic [127:0] acc_reg;
    logic [2:0]   cnt_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_half, b_half;
    logic [127:0] pp_shift;

    // select halves for this partial product
    always_comb begin
        a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        case (sh_reg)
            2'd0:    pp_shift = {64'd0, pp_reg};
            2'd1:    pp_shift = {32'd0, pp_reg, 32'd0};
            default: pp_shift = {pp_reg, 64'd0};
        endcase
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // multiply into the partial-product register, then accumulate from it
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (!cnt_reg[2]) begin
                pp_reg <= a_half * b_half;
                sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (cnt_reg != 3'd0) begin
                acc_reg <= acc_reg + pp_shift;
            end
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/bond_yield_bisection_core.sv
`default_nettype none

// channel   dir  tdata fields (low bit up)
// s_        in   face_value, coupon_rate, target_price, periods_per_year,
//                total_periods, rate_low, rate_high (240 bits)
// m_        out  yield_rate, result_status (40 bits)
// cfg_wr_   in   index 0 price_tolerance, index 1 iteration_limit
//
// one word is taken only when idle; a query then runs to its end
// one price costs two divider runs, one pass of the shared multiplier
// per period and two more passes for the coupon and face terms
// a query costs (2 + bisection steps) prices; the multiplier loop sets the pace
// reset is synchronous, active low; a stalled result holds and delays the next result
module bond_yield_bisection_core #(
    parameter int MaxPeriods = byb_pkg::MAX_PERIODS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // face, coupon, target, m, n, rate_low, rate_high
    input  wire logic [239:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // yield_rate, result_status
    output logic      [39:0]  m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_index,
    input  wire logic [31:0]  cfg_wr_data
);

    localparam int PeriodW = $clog2(MaxPeriods + 1);
    localparam int AnnW    = PeriodW + byb_pkg::DF_W;

    // which price is being evaluated
    localparam logic [1:0] PH_LOW  = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_MID  = 2'd2;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CDIV  = 10'b0000000010,
        ST_CPN   = 10'b0000000100,
        ST_JDIV  = 10'b0000001000,
        ST_DDIV  = 10'b0000010000,
        ST_PLOOP = 10'b0000100000,
        ST_MANN  = 10'b0001000000,
        ST_MFACE = 10'b0010000000,
        ST_GAP   = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg;
    logic   go_reg;

    logic [31:0] tol_reg;
    logic [15:0] iter_reg;

    logic [63:0]         face_reg, tgt_reg, cpn_reg, t1_reg, price_reg;
    logic [3:0]          m_reg;
    logic [PeriodW-1:0]  n_reg, i_reg;
    logic [31:0]         a_reg, b_reg, rate_reg;
    logic [28:0]         d_reg, p_reg;
    logic [AnnW-1:0]     ann_reg;
    logic [1:0]          phase_reg;
    logic                lo_pos_reg, lo_neg_reg;
    logic [15:0]         step_reg;
    logic [31:0]         yield_reg;
    logic [1:0]          stat_reg;
    logic                out_valid_reg;

    logic         div_start, div_done, mul_start, mul_done;
    logic [63:0]  div_num, div_quot, mul_a, mul_b;
    logic [32:0]  div_den;
    logic [127:0] mul_prod;

    logic [3:0]         m_in;
    logic [PeriodW-1:0] n_in;
    logic [28:0]        p_step;
    logic               gap_pos, gap_neg;
    logic [63:0]        gap_mag;
    logic [31:0]        a_upd, b_upd, mid_upd, mid_first;
    logic [16:0]        step_inc;
    logic [15:0]        limit;

    // input field fixes
    always_comb begin
        m_in = (s_tdata[163:160] == 4'd0) ? 4'd1 : s_tdata[163:160];
        if ({21'd0, s_tdata[174:164]} > 32'(MaxPeriods)) begin
            n_in = PeriodW'(MaxPeriods);
        end else begin
            n_in = PeriodW'(s_tdata[174:164]);
        end
    end

    // operand select for the shared units
    always_comb begin
        div_start = go_reg && (state_reg == ST_CDIV || state_reg == ST_JDIV ||
                               state_reg == ST_DDIV);
        mul_start = go_reg && (state_reg == ST_CPN || state_reg == ST_PLOOP ||
                               state_reg == ST_MANN || state_reg == ST_MFACE);
        div_num = {32'd0, rate_reg};
        div_den = {29'd0, m_reg};
        mul_a   = face_reg;
        mul_b   = {35'd0, p_reg};
        case (state_reg)
            ST_CDIV: begin
                div_num = {32'd0, yield_reg};
            end
            ST_DDIV: begin
                div_num = 64'd1 << 56;
                div_den = {1'b0, div_quot[31:0]} + {4'd0, byb_pkg::ONE_Q28};
            end
            ST_CPN: begin
                mul_b = {32'd0, div_quot[31:0]};
            end
            ST_PLOOP: begin
                mul_a = {35'd0, p_reg};
                mul_b = {35'd0, d_reg};
            end
            ST_MANN: begin
                mul_a = cpn_reg;
                mul_b = 64'(ann_reg);
            end
            default: begin
            end
        endcase
    end

    // gap and bisection update
    always_comb begin
        p_step   = mul_prod[56:28];
        gap_pos  = tgt_reg > price_reg;
        gap_neg  = tgt_reg < price_reg;
        gap_mag  = gap_neg ? (price_reg - tgt_reg) : (tgt_reg - price_reg);
        a_upd    = gap_pos ? a_reg : rate_reg;
        b_upd    = gap_pos ? rate_reg : b_reg;
        mid_upd  = {1'b0, a_upd[31:1]} + {1'b0, b_upd[31:1]} +
                   {31'd0, a_upd[0] & b_upd[0]};
        mid_first = {1'b0, a_reg[31:1]} + {1'b0, b_reg[31:1]} +
                    {31'd0, a_reg[0] & b_reg[0]};
        step_inc = {1'b0, step_reg} + 17'd1;
        limit    = (iter_reg == 16'd0) ? 16'd1 : iter_reg;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg  <= 32'd2;
            iter_reg <= 16'd50000;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == byb_pkg::CFG_TOL) begin
                tol_reg <= cfg_wr_data;
            end else begin
                iter_reg <= cfg_wr_data[15:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        face_reg  <= s_tdata[63:0];
                        yield_reg <= s_tdata[95:64];
                        tgt_reg   <= s_tdata[159:96];
                        m_reg     <= m_in;
                        n_reg     <= n_in;
                        a_reg     <= s_tdata[206:175];
                        b_reg     <= s_tdata[238:207];
                        rate_reg  <= s_tdata[206:175];
                        phase_reg <= PH_LOW;
                        go_reg    <= 1'b1;
                        state_reg <= ST_CDIV;
                    end
                end
                ST_CDIV: begin
                    if (div_done) begin
                        go_reg    <= 1'b1;
                        state_reg <= ST_CPN;
                    end
                end
                ST_CPN: begin
                    if (mul_done) begin
                        cpn_reg   <= byb_pkg::sat_q28(mul_prod);
                        go_reg    <= 1'b1;
                        state_reg <= ST_JDIV;
                    end
                end
                ST_JDIV: begin
                    if (div_done) begin
                        go_reg    <= 1'b1;
                        state_reg <= ST_DDIV;
                    end
                end
                ST_DDIV: begin
                    if (div_done) begin
                        d_reg   <= div_quot[28:0];
                        p_reg   <= byb_pkg::ONE_Q28;
                        ann_reg <= '0;
                        i_reg   <= '0;
                        go_reg  <= 1'b1;
                        state_reg <= (n_reg == '0) ? ST_MANN : ST_PLOOP;
                    end
                end
                ST_PLOOP: begin
                    if (mul_done) begin
                        p_reg   <= p_step;
                        ann_reg <= ann_reg + AnnW'(p_step);
                        i_reg   <= i_reg + PeriodW'(1);
                        go_reg  <= 1'b1;
                        if (i_reg + PeriodW'(1) == n_reg) begin
                            state_reg <= ST_MANN;
                        end
                    end
                end
                ST_MANN: begin
                    if (mul_done) begin
                        t1_reg    <= byb_pkg::sat_q28(mul_prod);
                        go_reg    <= 1'b1;
                        state_reg <= ST_MFACE;
                    end
                end
                ST_MFACE: begin
                    if (mul_done) begin
                        price_reg <= byb_pkg::add_sat(t1_reg, byb_pkg::sat_q28(mul_prod));
                        state_reg <= ST_GAP;
                    end
                end
                ST_GAP: begin
                    case (phase_reg)
                        PH_LOW: begin
                            lo_pos_reg <= gap_pos;
                            lo_neg_reg <= gap_neg;
                            rate_reg   <= b_reg;
                            phase_reg  <= PH_HIGH;
                            go_reg     <= 1'b1;
                            state_reg  <= ST_JDIV;
                        end
                        PH_HIGH: begin
                            if ((lo_pos_reg && gap_pos) || (lo_neg_reg && gap_neg)) begin
                                yield_reg <= '0;
                                stat_reg  <= byb_pkg::STAT_NO_BRACKET;
                                state_reg <= ST_DONE;
                            end else begin
                                rate_reg  <= mid_first;
                                step_reg  <= '0;
                                phase_reg <= PH_MID;
                                go_reg    <= 1'b1;
                                state_reg <= ST_JDIV;
                            end
                        end
                        default: begin
                            if (gap_mag < {32'd0, tol_reg}) begin
                                yield_reg <= rate_reg;
                                stat_reg  <= byb_pkg::STAT_CONVERGED;
                                state_reg <= ST_DONE;
                            end else if (step_inc >= {1'b0, limit}) begin
                                yield_reg <= rate_reg;
                                stat_reg  <= byb_pkg::STAT_LIMIT;
                                state_reg <= ST_DONE;
                            end else begin
                                a_reg     <= a_upd;
                                b_reg     <= b_upd;
                                rate_reg  <= mid_upd;
                                step_reg  <= step_inc[15:0];
                                go_reg    <= 1'b1;
                                state_reg <= ST_JDIV;
                            end
                        end
                    endcase
                end
                ST_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && (!out_valid_reg || m_tready)) begin
            m_tdata <= {6'd0, stat_reg, yield_reg};
        end
    end

    byb_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quot    (div_quot),
        .done    (div_done)
    );

    byb_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .prod    (mul_prod),
        .done    (mul_done)
    );

    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/byb_checker.sv
`default_nettype none

module byb_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [39:0]  m_tdata,
    input wire logic         m_tvalid,
    input wire logic         m_tready
);

    // a query keeps the input closed once its word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // status is one of the three codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] == byb_pkg::STAT_CONVERGED ||
                      m_tdata[33:32] == byb_pkg::STAT_NO_BRACKET ||
                      m_tdata[33:32] == byb_pkg::STAT_LIMIT))
        else $error("bad status code");

    // no bracket gives a zero yield
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[33:32] == byb_pkg::STAT_NO_BRACKET |-> m_tdata[31:0] == 32'd0)
        else $error("no-bracket yield not zero");

    // nothing shown straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind bond_yield_bisection_core byb_checker u_byb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
